FILE: rtl/core/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types, codes and defaults of the hierarchical timing wheel.
// ----------------------------------------------------------------------------
`default_nettype none

package htw_pkg;

  localparam int DEF_TIMER_ENTRIES = 64;
  localparam int DEF_LEVELS        = 5;
  localparam int DEF_WORK_BITS     = 8;
  localparam int DEF_ASSIST_BITS   = 6;

  localparam int MAX_RESULTS = 64;
  localparam int TIME_W      = 48;

  localparam logic [1:0] FN_REGISTER = 2'd0;
  localparam logic [1:0] FN_CANCEL   = 2'd1;
  localparam logic [1:0] FN_TICK     = 2'd2;

  localparam logic [2:0] ST_REGISTERED = 3'd0;
  localparam logic [2:0] ST_POOL_FULL  = 3'd1;
  localparam logic [2:0] ST_CANCELLED  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_FIRED      = 3'd4;
  localparam logic [2:0] ST_TICK_IDLE  = 3'd5;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ident_out;
    logic [15:0] fire_number;
    logic        last_of_run;
  } res_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_REG_SCAN, S_CAN_RD, S_CAN_CMP, S_UL_RD, S_UL_HEAD,
    S_UL_CHECK, S_UL_STEP, S_UL_FIX, S_DET_RD, S_DET_GOT, S_WALK_RD,
    S_WALK_GOT, S_FIRE_HOLD, S_PLACE, S_APPEND, S_EMIT, S_CAS_NEXT, S_TICK_END
  } state_t;

  typedef enum logic [1:0] {
    MODE_REG, MODE_CASCADE, MODE_FIRE
  } mode_t;

endpackage

`default_nettype wire

FILE: rtl/core/htw_if.sv
// ----------------------------------------------------------------------------
// htw_in_if / htw_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface htw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] delay_ticks;
  logic [31:0] repeat_interval;
  logic [15:0] fire_limit;
  logic [31:0] timer_ident;

  modport source (output valid, func, delay_ticks, repeat_interval, fire_limit,
                  timer_ident, input ready);
  modport sink   (input valid, func, delay_ticks, repeat_interval, fire_limit,
                  timer_ident, output ready);
endinterface

interface htw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] ident_out;
  logic [15:0] fire_number;
  logic        last_of_run;

  modport source (output valid, status, ident_out, fire_number, last_of_run,
                  input ready);
  modport sink   (input valid, status, ident_out, fire_number, last_of_run,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/htw_out_buf.sv
// ----------------------------------------------------------------------------
// htw_out_buf
// One-beat output register between the engine and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_out_buf
  import htw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  res_t      push_res,
  output logic      push_ok,
  htw_out_if.source out_bus
);

  logic full_r;
  logic full_nxt;
  res_t data_r;

  assign push_ok  = !full_r || out_bus.ready;
  assign full_nxt = push ? 1'b1 : (full_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
    if (push) begin
      data_r <= push_res;
    end
  end

  assign out_bus.valid       = full_r;
  assign out_bus.status      = data_r.status;
  assign out_bus.ident_out   = data_r.ident_out;
  assign out_bus.fire_number = data_r.fire_number;
  assign out_bus.last_of_run = data_r.last_of_run;

endmodule

`default_nettype wire

FILE: rtl/core/htw_engine.sv
// ----------------------------------------------------------------------------
// htw_engine
// Sequencer over the slot, link and entry memories of the timing wheel.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_engine
  import htw_pkg::*;
#(
  parameter int TIMER_ENTRIES = DEF_TIMER_ENTRIES,
  parameter int LEVELS        = DEF_LEVELS,
  parameter int WORK_BITS     = DEF_WORK_BITS,
  parameter int ASSIST_BITS   = DEF_ASSIST_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  htw_in_if.sink    in_bus,
  output logic      push,
  output res_t      push_res,
  input  wire logic push_ok
);

  localparam int WORK_SLOTS   = 2 ** WORK_BITS;
  localparam int ASSIST_SLOTS = 2 ** ASSIST_BITS;
  localparam int NSLOTS       = WORK_SLOTS + (LEVELS - 1) * ASSIST_SLOTS;
  localparam int SW = $clog2(NSLOTS);
  localparam int LW = $clog2(TIMER_ENTRIES + 1);
  localparam int EW = $clog2(TIMER_ENTRIES);
  localparam int PW = (WORK_BITS > ASSIST_BITS) ? WORK_BITS : ASSIST_BITS;
  localparam int NW = $clog2(LEVELS);
  localparam int KW = $clog2(MAX_RESULTS + 1);
  localparam logic [LW-1:0] NIL   = LW'(TIMER_ENTRIES);
  localparam logic [PW-1:0] WMASK = PW'(WORK_SLOTS - 1);
  localparam logic [PW-1:0] AMASK = PW'(ASSIST_SLOTS - 1);
  localparam logic [EW-1:0] LAST_ENTRY = EW'(TIMER_ENTRIES - 1);

  typedef struct packed {
    logic [LW-1:0] head;
    logic [LW-1:0] tail;
  } slot_ent_t;

  typedef struct packed {
    logic [31:0]       ident;
    logic [TIME_W-1:0] expire;
    logic [31:0]       interval;
    logic [15:0]       count;
    logic [15:0]       limit;
    logic [SW-1:0]     slot;
  } body_t;

  // slot of an assist level at a given position
  function automatic logic [SW-1:0] assist_slot(input logic [NW-1:0] n,
                                                input logic [PW-1:0] p);
    logic [SW-1:0] base;
    base = SW'(WORK_SLOTS + (int'(n) - 1) * ASSIST_SLOTS);
    return base + SW'(p & AMASK);
  endfunction

  // memories
  slot_ent_t     slot_mem [NSLOTS];
  logic [LW-1:0] link_mem [TIMER_ENTRIES];
  body_t         body_mem [TIMER_ENTRIES];

  logic          slot_we;
  logic [SW-1:0] slot_wa, slot_ra;
  slot_ent_t     slot_wd, slot_rd_r;
  logic          link_we;
  logic [EW-1:0] link_wa, link_ra;
  logic [LW-1:0] link_wd, link_rd_r;
  logic          body_we;
  logic [EW-1:0] body_wa, body_ra;
  body_t         body_wd, body_rd_r;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_r <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_r <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (body_we) begin
      body_mem[body_wa] <= body_wd;
    end
    body_rd_r <= body_mem[body_ra];
  end

  // control and working registers
  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [SW-1:0]       clr_r, clr_nxt;
  logic [EW-1:0]       scan_r, scan_nxt;
  logic [LW-1:0]       e_r, e_nxt;
  logic [LW-1:0]       nx_r, nx_nxt;
  logic [LW-1:0]       prev_r, prev_nxt;
  logic [LW-1:0]       walk_r, walk_nxt;
  logic [LW-1:0]       u_head_r, u_head_nxt;
  logic [LW-1:0]       u_tail_r, u_tail_nxt;
  logic [LW-1:0]       u_enext_r, u_enext_nxt;
  logic [SW-1:0]       u_slot_r, u_slot_nxt;
  logic [SW-1:0]       det_slot_r, det_slot_nxt;
  logic [31:0]         cur_ident_r, cur_ident_nxt;
  logic [TIME_W-1:0]   cur_exp_r, cur_exp_nxt;
  logic [31:0]         cur_ival_r, cur_ival_nxt;
  logic [15:0]         cur_cnt_r, cur_cnt_nxt;
  logic [15:0]         cur_lim_r, cur_lim_nxt;
  logic [31:0]         want_r, want_nxt;
  res_t                res_r, res_nxt;
  res_t                pend_r, pend_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [31:0]         nid_r, nid_nxt;
  logic [PW-1:0]       pos_r [LEVELS];
  logic [PW-1:0]       pos_nxt [LEVELS];
  logic [NW-1:0]       cas_n_r, cas_n_nxt;
  logic [TIMER_ENTRIES-1:0] valid_r, valid_nxt;

  // placement slot for the current entry
  logic [SW-1:0]     pl_slot;
  logic [TIME_W-1:0] left;
  logic [TIME_W-1:0] shifted;

  always_comb begin
    int sh;
    left    = cur_exp_r - now_r;
    pl_slot = SW'(cur_exp_r[WORK_BITS-1:0]);
    shifted = '0;
    for (int l = 1; l < LEVELS; l++) begin
      sh = WORK_BITS + ASSIST_BITS * (l - 1);
      if (sh < TIME_W && (left >> sh) != '0) begin
        shifted = cur_exp_r >> sh;
        pl_slot = SW'(WORK_SLOTS + (l - 1) * ASSIST_SLOTS)
                  + SW'(shifted[ASSIST_BITS-1:0]);
      end
    end
  end

  always_comb begin
    logic [PW-1:0] newpos;
    logic          keep;
    logic [31:0]   dly;

    state_nxt    = state_r;
    mode_nxt     = mode_r;
    clr_nxt      = clr_r;
    scan_nxt     = scan_r;
    e_nxt        = e_r;
    nx_nxt       = nx_r;
    prev_nxt     = prev_r;
    walk_nxt     = walk_r;
    u_head_nxt   = u_head_r;
    u_tail_nxt   = u_tail_r;
    u_enext_nxt  = u_enext_r;
    u_slot_nxt   = u_slot_r;
    det_slot_nxt = det_slot_r;
    cur_ident_nxt = cur_ident_r;
    cur_exp_nxt  = cur_exp_r;
    cur_ival_nxt = cur_ival_r;
    cur_cnt_nxt  = cur_cnt_r;
    cur_lim_nxt  = cur_lim_r;
    want_nxt     = want_r;
    res_nxt      = res_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    k_nxt        = k_r;
    now_nxt      = now_r;
    nid_nxt      = nid_r;
    pos_nxt      = pos_r;
    cas_n_nxt    = cas_n_r;
    valid_nxt    = valid_r;

    slot_we = 1'b0;
    slot_wa = u_slot_r;
    slot_wd = '{head: NIL, tail: NIL};
    slot_ra = det_slot_r;
    link_we = 1'b0;
    link_wa = e_r[EW-1:0];
    link_wd = NIL;
    link_ra = e_r[EW-1:0];
    body_we = 1'b0;
    body_wa = e_r[EW-1:0];
    body_wd = '{ident: cur_ident_r, expire: cur_exp_r, interval: cur_ival_r,
                count: cur_cnt_r, limit: cur_lim_r, slot: pl_slot};
    body_ra = scan_r;

    push     = 1'b0;
    push_res = res_r;
    in_bus.ready = 1'b0;

    newpos = '0;
    keep   = 1'b0;
    dly    = (in_bus.delay_ticks == '0) ? 32'd1 : in_bus.delay_ticks;

    case (state_r)
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_r;
        if (clr_r == SW'(NSLOTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_bus.valid) begin
          scan_nxt = '0;
          case (in_bus.func)
            FN_REGISTER: begin
              cur_exp_nxt  = now_r + TIME_W'(dly);
              cur_ival_nxt = (in_bus.repeat_interval == '0) ? 32'd1
                                                            : in_bus.repeat_interval;
              cur_cnt_nxt  = '0;
              cur_lim_nxt  = in_bus.fire_limit;
              state_nxt    = S_REG_SCAN;
            end
            FN_CANCEL: begin
              want_nxt  = in_bus.timer_ident;
              state_nxt = S_CAN_RD;
            end
            FN_TICK: begin
              k_nxt      = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_DET_RD;
              if (pos_r[0] == '0) begin
                cas_n_nxt    = NW'(1);
                det_slot_nxt = assist_slot(NW'(1), pos_r[1]);
                mode_nxt     = MODE_CASCADE;
              end else begin
                det_slot_nxt = SW'(pos_r[0] & WMASK);
                mode_nxt     = MODE_FIRE;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_REG_SCAN: begin
        if (!valid_r[scan_r]) begin
          valid_nxt[scan_r] = 1'b1;
          e_nxt         = LW'(scan_r);
          cur_ident_nxt = nid_r;
          nid_nxt       = nid_r + 1'b1;
          mode_nxt      = MODE_REG;
          res_nxt       = '{status: ST_REGISTERED, ident_out: nid_r,
                            fire_number: '0, last_of_run: 1'b1};
          state_nxt     = S_PLACE;
        end else if (scan_r == LAST_ENTRY) begin
          res_nxt   = '{status: ST_POOL_FULL, ident_out: '0,
                        fire_number: '0, last_of_run: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_CAN_RD: begin
        body_ra   = scan_r;
        state_nxt = S_CAN_CMP;
      end

      S_CAN_CMP: begin
        if (valid_r[scan_r] && body_rd_r.ident == want_r) begin
          valid_nxt[scan_r] = 1'b0;
          e_nxt      = LW'(scan_r);
          u_slot_nxt = body_rd_r.slot;
          res_nxt    = '{status: ST_CANCELLED, ident_out: want_r,
                         fire_number: '0, last_of_run: 1'b1};
          state_nxt  = S_UL_RD;
        end else if (scan_r == LAST_ENTRY) begin
          res_nxt   = '{status: ST_NOT_FOUND, ident_out: want_r,
                        fire_number: '0, last_of_run: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_CAN_RD;
        end
      end

      S_UL_RD: begin
        slot_ra   = u_slot_r;
        link_ra   = e_r[EW-1:0];
        state_nxt = S_UL_HEAD;
      end

      S_UL_HEAD: begin
        u_head_nxt  = slot_rd_r.head;
        u_tail_nxt  = slot_rd_r.tail;
        u_enext_nxt = link_rd_r;
        walk_nxt    = slot_rd_r.head;
        prev_nxt    = NIL;
        state_nxt   = S_UL_CHECK;
      end

      S_UL_CHECK: begin
        if (walk_r == e_r) begin
          state_nxt = S_UL_FIX;
        end else if (walk_r == NIL) begin
          state_nxt = S_EMIT;
        end else begin
          link_ra   = walk_r[EW-1:0];
          state_nxt = S_UL_STEP;
        end
      end

      S_UL_STEP: begin
        prev_nxt  = walk_r;
        walk_nxt  = link_rd_r;
        state_nxt = S_UL_CHECK;
      end

      S_UL_FIX: begin
        slot_we = 1'b1;
        slot_wa = u_slot_r;
        slot_wd.head = (prev_r == NIL) ? u_enext_r : u_head_r;
        slot_wd.tail = (u_tail_r == e_r) ? prev_r : u_tail_r;
        if (prev_r != NIL) begin
          link_we = 1'b1;
          link_wa = prev_r[EW-1:0];
          link_wd = u_enext_r;
        end
        state_nxt = S_EMIT;
      end

      S_DET_RD: begin
        // read the list head and empty the slot in the same cycle
        slot_ra   = det_slot_r;
        slot_we   = 1'b1;
        slot_wa   = det_slot_r;
        state_nxt = S_DET_GOT;
      end

      S_DET_GOT: begin
        e_nxt     = slot_rd_r.head;
        state_nxt = S_WALK_RD;
      end

      S_WALK_RD: begin
        if (e_r == NIL) begin
          state_nxt = (mode_r == MODE_CASCADE) ? S_CAS_NEXT : S_TICK_END;
        end else begin
          link_ra   = e_r[EW-1:0];
          body_ra   = e_r[EW-1:0];
          state_nxt = S_WALK_GOT;
        end
      end

      S_WALK_GOT: begin
        nx_nxt        = link_rd_r;
        cur_ident_nxt = body_rd_r.ident;
        cur_ival_nxt  = body_rd_r.interval;
        cur_lim_nxt   = body_rd_r.limit;
        if (mode_r == MODE_CASCADE) begin
          cur_exp_nxt = body_rd_r.expire;
          cur_cnt_nxt = body_rd_r.count;
          state_nxt   = S_PLACE;
        end else begin
          cur_exp_nxt = body_rd_r.expire + TIME_W'(body_rd_r.interval);
          cur_cnt_nxt = body_rd_r.count + 1'b1;
          res_nxt     = '{status: ST_FIRED, ident_out: body_rd_r.ident,
                          fire_number: body_rd_r.count + 1'b1, last_of_run: 1'b0};
          state_nxt   = S_FIRE_HOLD;
        end
      end

      S_FIRE_HOLD: begin
        // the newest report waits in pend_r until the next one shows up or the tick ends
        keep = 1'b1;
        if (k_r != KW'(MAX_RESULTS)) begin
          if (pend_v_r) begin
            if (push_ok) begin
              push     = 1'b1;
              push_res = pend_r;
              pend_nxt = res_r;
              k_nxt    = k_r + 1'b1;
            end else begin
              keep = 1'b0;
            end
          end else begin
            pend_nxt   = res_r;
            pend_v_nxt = 1'b1;
            k_nxt      = k_r + 1'b1;
          end
        end
        if (keep) begin
          if (cur_lim_r != '0 && cur_cnt_r >= cur_lim_r) begin
            valid_nxt[e_r[EW-1:0]] = 1'b0;
            e_nxt     = nx_r;
            state_nxt = S_WALK_RD;
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        slot_ra   = pl_slot;
        u_slot_nxt = pl_slot;
        link_we   = 1'b1;
        link_wa   = e_r[EW-1:0];
        link_wd   = NIL;
        body_we   = 1'b1;
        body_wa   = e_r[EW-1:0];
        state_nxt = S_APPEND;
      end

      S_APPEND: begin
        slot_we = 1'b1;
        slot_wa = u_slot_r;
        if (slot_rd_r.head == NIL) begin
          slot_wd = '{head: e_r, tail: e_r};
        end else begin
          slot_wd = '{head: slot_rd_r.head, tail: e_r};
          link_we = 1'b1;
          link_wa = slot_rd_r.tail[EW-1:0];
          link_wd = e_r;
        end
        if (mode_r == MODE_REG) begin
          state_nxt = S_EMIT;
        end else begin
          e_nxt     = nx_r;
          state_nxt = S_WALK_RD;
        end
      end

      S_EMIT: begin
        if (push_ok) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_CAS_NEXT: begin
        newpos = (pos_r[cas_n_r] + 1'b1) & AMASK;
        pos_nxt[cas_n_r] = newpos;
        state_nxt = S_DET_RD;
        if (newpos != PW'(1) || cas_n_r == NW'(LEVELS - 1)) begin
          mode_nxt     = MODE_FIRE;
          det_slot_nxt = SW'(pos_r[0] & WMASK);
        end else begin
          cas_n_nxt    = cas_n_r + 1'b1;
          det_slot_nxt = assist_slot(cas_n_r + 1'b1, pos_r[cas_n_r + 1'b1]);
        end
      end

      S_TICK_END: begin
        if (push_ok) begin
          push = 1'b1;
          if (pend_v_r) begin
            push_res = '{status: pend_r.status, ident_out: pend_r.ident_out,
                         fire_number: pend_r.fire_number, last_of_run: 1'b1};
          end else begin
            push_res = '{status: ST_TICK_IDLE, ident_out: '0,
                         fire_number: '0, last_of_run: 1'b1};
          end
          pend_v_nxt = 1'b0;
          now_nxt    = now_r + 1'b1;
          pos_nxt[0] = (pos_r[0] + 1'b1) & WMASK;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      valid_r  <= '0;
      now_r    <= '0;
      nid_r    <= 32'd1;
      pend_v_r <= 1'b0;
      k_r      <= '0;
      mode_r   <= MODE_REG;
      cas_n_r  <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      valid_r  <= valid_nxt;
      now_r    <= now_nxt;
      nid_r    <= nid_nxt;
      pend_v_r <= pend_v_nxt;
      k_r      <= k_nxt;
      mode_r   <= mode_nxt;
      cas_n_r  <= cas_n_nxt;
      pos_r    <= pos_nxt;
    end
    scan_r      <= scan_nxt;
    e_r         <= e_nxt;
    nx_r        <= nx_nxt;
    prev_r      <= prev_nxt;
    walk_r      <= walk_nxt;
    u_head_r    <= u_head_nxt;
    u_tail_r    <= u_tail_nxt;
    u_enext_r   <= u_enext_nxt;
    u_slot_r    <= u_slot_nxt;
    det_slot_r  <= det_slot_nxt;
    cur_ident_r <= cur_ident_nxt;
    cur_exp_r   <= cur_exp_nxt;
    cur_ival_r  <= cur_ival_nxt;
    cur_cnt_r   <= cur_cnt_nxt;
    cur_lim_r   <= cur_lim_nxt;
    want_r      <= want_nxt;
    res_r       <= res_nxt;
    pend_r      <= pend_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/hierarchical_timing_wheel_core.sv
// Register: a free-entry scan; cancel: an ident scan, then a walk of the slot list up
//   to the entry to unlink it.
// Tick: cascades each due assist level and its timers, then fires the timers of the work slot.
// One command at a time; a finished result waits in the output register meanwhile.
// Reset (rst_n low, synchronous): time, idents, positions and pool cleared, then
//   a clearing pass over all NSLOTS slots (512 by default) empties the slot memory.
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel_core
// Hierarchical timing wheel: register, cancel and tick over a fixed timer pool.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_timing_wheel_core
  import htw_pkg::*;
#(
  parameter int TIMER_ENTRIES = DEF_TIMER_ENTRIES,
  parameter int LEVELS        = DEF_LEVELS,
  parameter int WORK_BITS     = DEF_WORK_BITS,
  parameter int ASSIST_BITS   = DEF_ASSIST_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  htw_in_if.sink    in_bus,
  htw_out_if.source out_bus
);

  // engine -> output register: one result beat per push
  logic push;
  logic push_ok;
  res_t push_res;

  // Engine: slot head/tail memory, link memory and entry body memory, each
  // one write and one registered read port, driven by a single sequencer.
  htw_engine #(
    .TIMER_ENTRIES (TIMER_ENTRIES),
    .LEVELS        (LEVELS),
    .WORK_BITS     (WORK_BITS),
    .ASSIST_BITS   (ASSIST_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .push     (push),
    .push_res (push_res),
    .push_ok  (push_ok)
  );

  // Output register: decouples the result channel from the sequencer so the
  // next command can be taken while the last beat is still waiting.
  htw_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .push_ok  (push_ok),
    .out_bus  (out_bus)
  );

endmodule

`default_nettype wire

FILE: rtl/core/htw_checker.sv
// ----------------------------------------------------------------------------
// htw_checker
// Port-level checks on the result channel of the timing wheel.
// ----------------------------------------------------------------------------
`default_nettype none

module htw_checker
  import htw_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [31:0] ident_out,
  input wire logic [15:0] fire_number,
  input wire logic        last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ident_out) && $stable(status))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= ST_TICK_IDLE)
    else $error("bad status code");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_FIRED |-> last_of_run && fire_number == '0)
    else $error("non-fire result must be a single last beat");

  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_POOL_FULL || status == ST_TICK_IDLE) |-> ident_out == '0)
    else $error("pool_full or idle beat with nonzero ident");

endmodule

bind hierarchical_timing_wheel_core htw_checker u_htw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .status      (out_bus.status),
  .ident_out   (out_bus.ident_out),
  .fire_number (out_bus.fire_number),
  .last_of_run (out_bus.last_of_run)
);

`default_nettype wire

FILE: tb/tb_hierarchical_timing_wheel_core.sv
// ----------------------------------------------------------------------------
// tb_hierarchical_timing_wheel_core
// Self-checking bench: directed table then random register/cancel/tick beats,
// each result beat checked against a typed-in beat or a behavioral timing wheel model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hierarchical_timing_wheel_core;
  import htw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL   = DEF_TIMER_ENTRIES;
  localparam int NLVL   = DEF_LEVELS;
  localparam int WBITS  = DEF_WORK_BITS;
  localparam int ABITS  = DEF_ASSIST_BITS;
  localparam int NSLOT  = (1 << WBITS) + (NLVL - 1) * (1 << ABITS);
  localparam int NIL    = POOL;
  localparam int N_RAND = 405;

  logic clk;
  logic rst_n;

  htw_in_if  cmd_bus ();
  htw_out_if res_bus ();

  hierarchical_timing_wheel_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (cmd_bus.sink),
    .out_bus (res_bus.source)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // --------------------------------------------------------------------------
  // Behavioral wheel: own copy of time, positions, slot lists and timer pool.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] wh_now;
  logic [31:0]       wh_next_id;
  int                wh_pos   [NLVL];
  int                wh_head  [NSLOT];
  int                wh_tail  [NSLOT];
  int                tm_link  [POOL];
  int                tm_slot  [POOL];
  logic [31:0]       tm_id    [POOL];
  logic [TIME_W-1:0] tm_exp   [POOL];
  logic [31:0]       tm_ivl   [POOL];
  logic [15:0]       tm_cnt   [POOL];
  logic [15:0]       tm_lim   [POOL];
  bit                tm_live  [POOL];

  res_t pending_res[$];   // results still owed by the block, oldest first
  bit   failed;

  function automatic int lvl_mask(int l);
    return (l == 0) ? (1 << WBITS) - 1 : (1 << ABITS) - 1;
  endfunction

  function automatic int lvl_base(int l);
    return (l == 0) ? 0 : (1 << WBITS) + (l - 1) * (1 << ABITS);
  endfunction

  function automatic void slot_push(int s, int e);
    tm_link[e] = NIL;
    if (wh_head[s] == NIL) begin
      wh_head[s] = e;
    end else begin
      tm_link[wh_tail[s]] = e;
    end
    wh_tail[s] = e;
    tm_slot[e] = s;
  endfunction

  // Highest level whose slot unit fits in the remaining ticks.
  function automatic void slot_place(int e);
    logic [TIME_W-1:0] left;
    int sh;
    left = tm_exp[e] - wh_now;
    for (int l = NLVL - 1; l >= 1; l--) begin
      sh = WBITS + ABITS * (l - 1);
      if (sh < TIME_W && left >= (48'd1 << sh)) begin
        slot_push(lvl_base(l) + int'((tm_exp[e] >> sh) & lvl_mask(l)), e);
        return;
      end
    end
    slot_push(int'(tm_exp[e] & lvl_mask(0)), e);
  endfunction

  function automatic int slot_take(int s);
    int h;
    h = wh_head[s];
    wh_head[s] = NIL;
    wh_tail[s] = NIL;
    return h;
  endfunction

  function automatic void wheel_reset();
    wh_now = '0;
    wh_next_id = 32'd1;
    foreach (wh_pos[i]) wh_pos[i] = 0;
    foreach (wh_head[i]) begin
      wh_head[i] = NIL;
      wh_tail[i] = NIL;
    end
    foreach (tm_live[i]) begin
      tm_live[i] = 1'b0;
      tm_slot[i] = NSLOT;
      tm_link[i] = NIL;
    end
  endfunction

  function automatic res_t mk_res(logic [2:0] st, logic [31:0] id, logic [15:0] fn,
                                  logic last);
    res_t r;
    r.status = st;
    r.ident_out = id;
    r.fire_number = fn;
    r.last_of_run = last;
    return r;
  endfunction

  // Applies one command to the model and returns the result beats it causes.
  function automatic void wheel_step(input logic [1:0] fn, input logic [31:0] dly,
                                     input logic [31:0] ivl, input logic [15:0] lim,
                                     input logic [31:0] tid, ref res_t rq[$]);
    int i, e, nx, n, prev, cur, s;
    rq.delete();
    case (fn)
      FN_REGISTER: begin
        for (i = 0; i < POOL; i++) if (!tm_live[i]) break;
        if (i >= POOL) begin
          rq.push_back(mk_res(ST_POOL_FULL, '0, '0, 1'b1));
          return;
        end
        tm_live[i] = 1'b1;
        tm_id[i] = wh_next_id;
        wh_next_id = wh_next_id + 1;
        tm_exp[i] = wh_now + ((dly == 0) ? 32'd1 : dly);
        tm_ivl[i] = (ivl == 0) ? 32'd1 : ivl;
        tm_cnt[i] = '0;
        tm_lim[i] = lim;
        slot_place(i);
        rq.push_back(mk_res(ST_REGISTERED, tm_id[i], '0, 1'b1));
      end
      FN_CANCEL: begin
        for (i = 0; i < POOL; i++) begin
          if (tm_live[i] && tm_id[i] == tid) begin
            s = tm_slot[i];
            if (s < NSLOT) begin
              prev = NIL;
              cur = wh_head[s];
              while (cur != NIL && cur != i) begin
                prev = cur;
                cur = tm_link[cur];
              end
              if (cur != NIL) begin
                if (prev == NIL) wh_head[s] = tm_link[i];
                else tm_link[prev] = tm_link[i];
                if (wh_tail[s] == i) wh_tail[s] = prev;
              end
            end
            tm_live[i] = 1'b0;
            rq.push_back(mk_res(ST_CANCELLED, tid, '0, 1'b1));
            return;
          end
        end
        rq.push_back(mk_res(ST_NOT_FOUND, tid, '0, 1'b1));
      end
      FN_TICK: begin
        // work wheel at position 0: cascade upward while each level wraps
        if (wh_pos[0] == 0) begin
          n = 1;
          forever begin
            e = slot_take(lvl_base(n) + wh_pos[n]);
            while (e != NIL) begin
              nx = tm_link[e];
              slot_place(e);
              e = nx;
            end
            wh_pos[n] = (wh_pos[n] + 1) & lvl_mask(n);
            if (wh_pos[n] != 1) break;
            n++;
            if (n >= NLVL) break;
          end
        end
        e = slot_take(wh_pos[0]);
        while (e != NIL) begin
          nx = tm_link[e];
          tm_cnt[e] = tm_cnt[e] + 1;
          if (rq.size() < MAX_RESULTS)
            rq.push_back(mk_res(ST_FIRED, tm_id[e], tm_cnt[e], 1'b0));
          if (tm_lim[e] != 0 && tm_cnt[e] >= tm_lim[e]) begin
            tm_live[e] = 1'b0;
            tm_slot[e] = NSLOT;
          end else begin
            tm_exp[e] = tm_exp[e] + tm_ivl[e];
            slot_place(e);
          end
          e = nx;
        end
        wh_now = wh_now + 1;
        wh_pos[0] = (wh_pos[0] + 1) & lvl_mask(0);
        if (rq.size() == 0) rq.push_back(mk_res(ST_TICK_IDLE, '0, '0, 1'b1));
        else rq[rq.size() - 1].last_of_run = 1'b1;
      end
      default: ;  // unused code: no result
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command table and generator
  // --------------------------------------------------------------------------
  typedef struct {
    logic [1:0]  fn;
    logic [31:0] dly;
    logic [31:0] ivl;
    logic [15:0] lim;
    logic [31:0] tid;
    bit          fixed;   // expected beat typed in below
    res_t        want;
  } cmd_t;

  cmd_t cmd_tab[$];

  function automatic cmd_t mk_cmd(logic [1:0] fn, logic [31:0] dly, logic [31:0] ivl,
                                  logic [15:0] lim, logic [31:0] tid);
    cmd_t c;
    c.fn = fn;
    c.dly = dly;
    c.ivl = ivl;
    c.lim = lim;
    c.tid = tid;
    c.fixed = 1'b0;
    c.want = '0;
    return c;
  endfunction

  function automatic cmd_t mk_fixed(logic [1:0] fn, logic [31:0] dly, logic [31:0] ivl,
                                    logic [15:0] lim, logic [31:0] tid, res_t w);
    cmd_t c;
    c = mk_cmd(fn, dly, ivl, lim, tid);
    c.fixed = 1'b1;
    c.want = w;
    return c;
  endfunction

  function automatic logic [31:0] pick_span(int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, (phase == 1) ? 12 : 300);
    if (r < 90) return $urandom_range(256, 70000);
    return $urandom();
  endfunction

  // phase 0: fill the pool, 1: tick heavy, 2: cancel heavy
  function automatic cmd_t rand_cmd(int phase);
    int r, t_reg, t_can;
    logic [15:0] lim;
    logic [31:0] tid;
    r = $urandom_range(0, 99);
    t_reg = (phase == 0) ? 80 : (phase == 1) ? 15 : 20;
    t_can = (phase == 2) ? t_reg + 50 : t_reg + 8;
    if (r < t_reg) begin
      lim = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
      return mk_cmd(FN_REGISTER, pick_span(phase), pick_span(phase), lim, $urandom());
    end
    if (r < t_can) begin
      tid = ($urandom_range(0, 5) == 0) ? $urandom()
                                        : wh_next_id - $urandom_range(1, 70);
      return mk_cmd(FN_CANCEL, $urandom(), $urandom(), 16'($urandom()), tid);
    end
    if (r == 99) return mk_cmd(2'd3, $urandom(), $urandom(), 16'($urandom()), $urandom());
    return mk_cmd(FN_TICK, $urandom(), $urandom(), 16'($urandom()), $urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts and gaps, inputs change on the falling edge
  // --------------------------------------------------------------------------
  task automatic send_cmd(cmd_t c);
    res_t beats[$];
    cmd_bus.valid = 1'b1;
    cmd_bus.func = c.fn;
    cmd_bus.delay_ticks = c.dly;
    cmd_bus.repeat_interval = c.ivl;
    cmd_bus.fire_limit = c.lim;
    cmd_bus.timer_ident = c.tid;
    do @(posedge clk); while (!cmd_bus.ready);
    wheel_step(c.fn, c.dly, c.ivl, c.lim, c.tid, beats);
    if (c.fixed) begin
      pending_res.push_back(c.want);
    end else begin
      foreach (beats[i]) pending_res.push_back(beats[i]);
    end
    @(negedge clk);
  endtask

  int burst_left;

  task automatic sender_pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    cmd_bus.valid = 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern of its own, checks on the rising edge
  // --------------------------------------------------------------------------
  logic [15:0] stall_pat;
  int          pat_left;

  always @(negedge clk) begin
    if (pat_left == 0) begin
      pat_left <= $urandom_range(8, 60);
      case ($urandom_range(0, 3))
        0: stall_pat <= 16'hFFFF;          // no stalls for a while
        1: stall_pat <= 16'h0F0F;
        default: stall_pat <= 16'($urandom()) | 16'h1111;
      endcase
    end else begin
      pat_left <= pat_left - 1;
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    res_bus.ready <= stall_pat[15];
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result beat: status %0d ident %0d", res_bus.status,
               res_bus.ident_out);
        failed = 1'b1;
      end else begin
        exp_r = pending_res.pop_front();
        if (res_bus.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, res_bus.status);
          failed = 1'b1;
        end
        if (res_bus.ident_out !== exp_r.ident_out) begin
          $error("ident_out: expected %0d, got %0d", exp_r.ident_out,
                 res_bus.ident_out);
          failed = 1'b1;
        end
        if (res_bus.fire_number !== exp_r.fire_number) begin
          $error("fire_number: expected %0d, got %0d", exp_r.fire_number,
                 res_bus.fire_number);
          failed = 1'b1;
        end
        if (res_bus.last_of_run !== exp_r.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", exp_r.last_of_run,
                 res_bus.last_of_run);
          failed = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase, wait_cyc;
    failed = 1'b0;
    burst_left = 0;
    pat_left = 0;
    stall_pat = 16'hFFFF;
    res_bus.ready = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.func = FN_TICK;
    cmd_bus.delay_ticks = '0;
    cmd_bus.repeat_interval = '0;
    cmd_bus.fire_limit = '0;
    cmd_bus.timer_ident = '0;
    rst_n = 1'b0;
    wheel_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    cmd_tab.push_back(mk_fixed(FN_TICK, '0, '0, '0, '0,
                               mk_res(ST_TICK_IDLE, '0, '0, 1'b1)));
    cmd_tab.push_back(mk_fixed(FN_CANCEL, '0, '0, '0, '0,
                               mk_res(ST_NOT_FOUND, '0, '0, 1'b1)));
    // zero delay and interval run as one tick; limit of two
    cmd_tab.push_back(mk_fixed(FN_REGISTER, '0, '0, 16'd2, '0,
                               mk_res(ST_REGISTERED, 32'd1, '0, 1'b1)));
    cmd_tab.push_back(mk_cmd(FN_TICK, '0, '0, '0, '0));
    cmd_tab.push_back(mk_cmd(FN_TICK, '0, '0, '0, '0));
    cmd_tab.push_back(mk_cmd(FN_TICK, '0, '0, '0, '0));
    // expired by limit: cancel finds nothing
    cmd_tab.push_back(mk_fixed(FN_CANCEL, '0, '0, '0, 32'd1,
                               mk_res(ST_NOT_FOUND, 32'd1, '0, 1'b1)));
    cmd_tab.push_back(mk_fixed(FN_REGISTER, '1, '1, '1, '1,
                               mk_res(ST_REGISTERED, 32'd2, '0, 1'b1)));
    cmd_tab.push_back(mk_fixed(FN_REGISTER, 32'd300, 32'd5, '0, '0,
                               mk_res(ST_REGISTERED, 32'd3, '0, 1'b1)));
    cmd_tab.push_back(mk_fixed(FN_CANCEL, '0, '0, '0, 32'd2,
                               mk_res(ST_CANCELLED, 32'd2, '0, 1'b1)));
    cmd_tab.push_back(mk_fixed(FN_CANCEL, '1, '1, '1, '1,
                               mk_res(ST_NOT_FOUND, '1, '0, 1'b1)));
    cmd_tab.push_back(mk_cmd(2'd3, '1, '1, '1, '1));   // unused code, no beat
    // unlimited every-tick timer, two sharing one slot (FIFO order) and one on an assist level
    cmd_tab.push_back(mk_cmd(FN_REGISTER, 32'd1, 32'd1, '0, '0));
    cmd_tab.push_back(mk_cmd(FN_REGISTER, 32'd2, 32'd3, 16'd3, '0));
    cmd_tab.push_back(mk_cmd(FN_REGISTER, 32'd2, 32'd3, 16'd1, '0));
    cmd_tab.push_back(mk_cmd(FN_REGISTER, 32'd256, 32'd64, '0, '0));
    for (int i = 0; i < 6; i++) cmd_tab.push_back(mk_cmd(FN_TICK, '0, '0, '0, '0));
    cmd_tab.push_back(mk_cmd(FN_CANCEL, '0, '0, '0, 32'd3));
    cmd_tab.push_back(mk_cmd(FN_CANCEL, '0, '0, '0, 32'd4));

    foreach (cmd_tab[i]) begin
      send_cmd(cmd_tab[i]);
      sender_pace();
    end

    // random part, phase picked at random every 45 commands
    phase = 0;
    for (int i = 0; i < N_RAND; i++) begin
      if (i % 45 == 0) phase = (i == 0) ? 0 : $urandom_range(0, 2);
      send_cmd(rand_cmd(phase));
      sender_pace();
    end
    cmd_bus.valid = 1'b0;

    wait_cyc = 0;
    while (pending_res.size() != 0 && wait_cyc < 200000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (300) @(posedge clk);

    if (!failed && pending_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending_res.size() != 0)
        $error("%0d expected result beats never arrived", pending_res.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
